### src/m3i_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the 3x3 inverse / determinant core
// no dependencies

package m3i_pkg;

    localparam int WORD          = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int N_ENT         = 9;
    localparam int N_ROW         = 3;
    localparam int W_PROD        = 2 * WORD;
    localparam int W_COF         = W_PROD + 1;
    localparam int W_PP          = W_COF;
    localparam int W_DET         = W_COF + WORD + 2;

    typedef logic signed [WORD-1:0]   t_word;
    typedef logic signed [W_PROD-1:0] t_prod;
    typedef logic signed [W_COF-1:0]  t_cof;
    typedef logic signed [W_PP-1:0]   t_pp;
    typedef logic signed [W_DET-1:0]  t_det;

    typedef t_word t_mat [N_ENT];
    typedef t_word t_row [N_ROW];
    typedef t_cof  t_adj [N_ENT];

    typedef struct packed {
        logic [N_ENT-1:0][WORD-1:0] inv;
        logic [WORD-1:0]            det;
        logic                       singular;
    } t_res;

    // cofactor k (already transposed) = m[A]*m[B] - m[C]*m[D]
    localparam int COF_A [N_ENT] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
    localparam int COF_B [N_ENT] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
    localparam int COF_C [N_ENT] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
    localparam int COF_D [N_ENT] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

    localparam logic [WORD-1:0] MIN_MAG  = {1'b1, {(WORD-1){1'b0}}};
    localparam t_word           WORD_MIN = t_word'(MIN_MAG);
    localparam t_word           WORD_MAX = t_word'(~MIN_MAG);

    // sign + magnitude to saturated two's complement word
    function automatic t_word sat_word(input logic neg, input logic ovf,
                                       input logic [WORD-1:0] mag);
        t_word res;
        if (neg) begin
            if (ovf || (mag > MIN_MAG)) res = WORD_MIN;
            else                        res = t_word'(~mag + 1'b1);
        end else begin
            if (ovf || mag[WORD-1]) res = WORD_MAX;
            else                    res = t_word'(mag);
        end
        return res;
    endfunction

endpackage

### src/m3i_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for matrix beats and result beats
// depends on m3i_pkg

interface m3i_in_if;
    import m3i_pkg::*;
    logic  valid;
    logic  ready;
    t_word m00, m01, m02, m10, m11, m12, m20, m21, m22;
    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

interface m3i_out_if;
    import m3i_pkg::*;
    logic  valid;
    logic  ready;
    t_word inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    t_word determinant;
    logic  singular;
    modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, determinant, singular, input ready);
    modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, determinant, singular, output ready);
endinterface

### src/m3i_cofactor.sv
`timescale 1ns / 1ps
// two-stage cofactor unit: 18 products, then nine exact differences
// depends on m3i_pkg

module m3i_cofactor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  m3i_pkg::t_mat i_m,
    output logic          o_valid,
    output m3i_pkg::t_adj o_adj,
    output m3i_pkg::t_row o_row0
);
    import m3i_pkg::*;

    logic  r_va, r_vb;
    t_prod r_pa [N_ENT];
    t_prod r_pb [N_ENT];
    t_prod n_pa [N_ENT];
    t_prod n_pb [N_ENT];
    t_row  r_row_a, r_row_b;
    t_adj  r_adj, n_adj;

    always_comb begin
        for (int k = 0; k < N_ENT; k++) begin
            n_pa[k]  = i_m[COF_A[k]] * i_m[COF_B[k]];
            n_pb[k]  = i_m[COF_C[k]] * i_m[COF_D[k]];
            n_adj[k] = t_cof'(r_pa[k]) - t_cof'(r_pb[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa    <= n_pa;
            r_pb    <= n_pb;
            r_row_a <= '{i_m[0], i_m[1], i_m[2]};
            r_row_b <= r_row_a;
            r_adj   <= n_adj;
        end
    end

    assign o_valid = r_vb;
    assign o_adj   = r_adj;
    assign o_row0  = r_row_b;

endmodule

### src/m3i_det.sv
`timescale 1ns / 1ps
// three-stage determinant: split 32x65 products, recombine, sum the row
// depends on m3i_pkg

module m3i_det (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  m3i_pkg::t_adj i_adj,
    input  m3i_pkg::t_row i_row0,
    output logic          o_valid,
    output m3i_pkg::t_adj o_adj,
    output m3i_pkg::t_det o_det
);
    import m3i_pkg::*;

    logic [2:0] r_v;
    t_pp  r_pl [N_ROW];
    t_pp  r_ph [N_ROW];
    t_pp  n_pl [N_ROW];
    t_pp  n_ph [N_ROW];
    t_det r_t  [N_ROW];
    t_det n_t  [N_ROW];
    t_det r_det, n_det;
    t_adj r_adj_c, r_adj_d, r_adj_e;

    always_comb begin
        for (int i = 0; i < N_ROW; i++) begin
            // cofactor split into unsigned low word and signed high part
            n_pl[i] = i_row0[i] * $signed({1'b0, i_adj[3*i][WORD-1:0]});
            n_ph[i] = i_row0[i] * $signed(i_adj[3*i][W_COF-1:WORD]);
            n_t[i]  = (t_det'(r_ph[i]) <<< WORD) + t_det'(r_pl[i]);
        end
        n_det = r_t[0] + r_t[1] + r_t[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl    <= n_pl;
            r_ph    <= n_ph;
            r_t     <= n_t;
            r_det   <= n_det;
            r_adj_c <= i_adj;
            r_adj_d <= r_adj_c;
            r_adj_e <= r_adj_d;
        end
    end

    assign o_valid = r_v[2];
    assign o_adj   = r_adj_e;
    assign o_det   = r_det;

endmodule

### src/m3i_divider.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage for nine lanes,
// with sign handling, overflow detect and final saturation; uses m3i_pkg

module m3i_divider #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  m3i_pkg::t_adj i_adj,
    input  m3i_pkg::t_det i_det,
    output logic          o_valid,
    output m3i_pkg::t_res o_res
);
    import m3i_pkg::*;

    localparam int W_AMAG = W_COF - 1;
    localparam int W_DMAG = W_DET - 1;
    localparam int W_NUM  = W_AMAG + 2 * FRAC_BITS;
    localparam int W_DQ   = W_DMAG + WORD;
    localparam int W_DIV  = ((W_NUM > W_DQ) ? W_NUM : W_DQ) + 1;
    localparam int N_ST   = WORD;

    // prep stage
    logic                r_fv;
    logic                r_dneg, n_dneg;
    logic [W_DMAG-1:0]   r_dmag, n_dmag;
    logic [N_ENT-1:0]    r_aneg, n_aneg;
    logic [W_AMAG-1:0]   r_amag [N_ENT];
    logic [W_AMAG-1:0]   n_amag [N_ENT];
    logic                r_sing, n_sing;
    t_word               r_detw, n_detw;
    logic [W_DET-1:0]    w_dabs, w_dsh;

    // quotient stages, index 0 is the overflow-check stage
    logic [N_ST:0]       r_st_v;
    logic [W_DIV-1:0]    r_rem  [N_ST+1][N_ENT];
    logic [W_DIV-1:0]    n_rem  [N_ST+1][N_ENT];
    logic [WORD-1:0]     r_q    [N_ST+1][N_ENT];
    logic [WORD-1:0]     n_q    [N_ST+1][N_ENT];
    logic [N_ENT-1:0]    r_ovf  [N_ST+1];
    logic [N_ENT-1:0]    n_ovf0;
    logic [W_DMAG-1:0]   r_sdm  [N_ST+1];
    logic [N_ENT-1:0]    r_san  [N_ST+1];
    logic                r_sdn  [N_ST+1];
    logic                r_ssg  [N_ST+1];
    t_word               r_sdw  [N_ST+1];

    // output format stage
    logic                r_ov;
    t_res                r_res, n_res;

    always_comb begin : p_prep
        logic [W_COF-1:0] v_abs;
        n_dneg = i_det[W_DET-1];
        w_dabs = n_dneg ? W_DET'(-i_det) : W_DET'(i_det);
        n_dmag = w_dabs[W_DMAG-1:0];
        w_dsh  = w_dabs >> (2 * FRAC_BITS);
        n_detw = sat_word(n_dneg, |w_dsh[W_DET-1:WORD], w_dsh[WORD-1:0]);
        n_sing = (i_det == '0);
        for (int k = 0; k < N_ENT; k++) begin
            n_aneg[k] = i_adj[k][W_COF-1];
            v_abs     = n_aneg[k] ? W_COF'(-i_adj[k]) : W_COF'(i_adj[k]);
            n_amag[k] = v_abs[W_AMAG-1:0];
        end
    end

    always_comb begin : p_steps
        logic [W_DIV-1:0] v_dsh;
        for (int k = 0; k < N_ENT; k++) begin
            n_rem[0][k] = W_DIV'(r_amag[k]) << (2 * FRAC_BITS);
            n_q[0][k]   = '0;
            // quotient needs more than one word: saturate
            n_ovf0[k]   = n_rem[0][k] >= (W_DIV'(r_dmag) << WORD);
        end
        for (int s = 0; s < N_ST; s++) begin
            for (int k = 0; k < N_ENT; k++) begin
                v_dsh         = W_DIV'(r_sdm[s]) << (N_ST - 1 - s);
                n_rem[s+1][k] = r_rem[s][k];
                n_q[s+1][k]   = r_q[s][k];
                if (r_rem[s][k] >= v_dsh) begin
                    n_rem[s+1][k]          = r_rem[s][k] - v_dsh;
                    n_q[s+1][k][N_ST-1-s]  = 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < N_ENT; k++) begin
            n_res.inv[k] = r_ssg[N_ST] ? '0 :
                sat_word(r_san[N_ST][k] ^ r_sdn[N_ST], r_ovf[N_ST][k], r_q[N_ST][k]);
        end
        n_res.det      = r_ssg[N_ST] ? '0 : r_sdw[N_ST];
        n_res.singular = r_ssg[N_ST];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv   <= 1'b0;
            r_st_v <= '0;
            r_ov   <= 1'b0;
        end else if (i_en) begin
            r_fv   <= i_valid;
            r_st_v <= {r_st_v[N_ST-1:0], r_fv};
            r_ov   <= r_st_v[N_ST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dneg   <= n_dneg;
            r_dmag   <= n_dmag;
            r_aneg   <= n_aneg;
            r_amag   <= n_amag;
            r_sing   <= n_sing;
            r_detw   <= n_detw;
            r_ovf[0] <= n_ovf0;
            r_sdm[0] <= r_dmag;
            r_san[0] <= r_aneg;
            r_sdn[0] <= r_dneg;
            r_ssg[0] <= r_sing;
            r_sdw[0] <= r_detw;
            r_rem[0] <= n_rem[0];
            r_q[0]   <= n_q[0];
            for (int s = 0; s < N_ST; s++) begin
                r_rem[s+1] <= n_rem[s+1];
                r_q[s+1]   <= n_q[s+1];
                r_ovf[s+1] <= r_ovf[s];
                r_sdm[s+1] <= r_sdm[s];
                r_san[s+1] <= r_san[s];
                r_sdn[s+1] <= r_sdn[s];
                r_ssg[s+1] <= r_ssg[s];
                r_sdw[s+1] <= r_sdw[s];
            end
            r_res <= n_res;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

endmodule

### src/m3i_skid.sv
`timescale 1ns / 1ps
// output register plus skid slot; stalls the pipeline only when both are full
// depends on m3i_pkg

module m3i_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  m3i_pkg::t_res i_data,
    output logic          o_en,
    output logic          o_valid,
    output m3i_pkg::t_res o_data,
    input  logic          i_ready
);
    import m3i_pkg::*;

    logic r_out_v, r_skid_v;
    t_res r_out, r_skid;

    assign o_en = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_ready) begin
            r_out_v  <= r_skid_v | i_valid;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v && i_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_ready) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end else if (!r_skid_v) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

### src/matrix3x3_inverse_det.sv
`timescale 1ns / 1ps
// throughput: one matrix per cycle unless stalled; 32 quotient stages set the depth
// backpressure: a full output register plus skid slot holds the whole pipeline
// reset: synchronous active low, clears valid bits only, no warm-up
// depends on m3i_pkg, m3i_if, m3i_cofactor, m3i_det, m3i_divider, m3i_skid

module matrix3x3_inverse_det_core #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    m3i_in_if.sink    i_mat,
    m3i_out_if.source o_res
);
    import m3i_pkg::*;

    // global advance, low only while the skid slot is occupied
    logic w_en;

    // input beat unpacked into row-major order
    t_mat w_m;

    // cofactor stage outputs
    logic w_cof_v;
    t_adj w_cof_adj;
    t_row w_cof_row0;

    // determinant stage outputs
    logic w_det_v;
    t_adj w_det_adj;
    t_det w_det;

    // divider outputs
    logic w_div_v;
    t_res w_div_res;

    // result beat
    logic w_out_v;
    t_res w_out;

    assign w_m[0] = i_mat.m00;
    assign w_m[1] = i_mat.m01;
    assign w_m[2] = i_mat.m02;
    assign w_m[3] = i_mat.m10;
    assign w_m[4] = i_mat.m11;
    assign w_m[5] = i_mat.m12;
    assign w_m[6] = i_mat.m20;
    assign w_m[7] = i_mat.m21;
    assign w_m[8] = i_mat.m22;

    // every stage moves together, so accept whenever the pipeline advances
    assign i_mat.ready = w_en;

    // exact 2x2 minors, already transposed into adjugate order
    m3i_cofactor u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_mat.valid),
        .i_m     (w_m),
        .o_valid (w_cof_v),
        .o_adj   (w_cof_adj),
        .o_row0  (w_cof_row0)
    );

    // first-row expansion, exact at triple fraction scale
    m3i_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cof_v),
        .i_adj   (w_cof_adj),
        .i_row0  (w_cof_row0),
        .o_valid (w_det_v),
        .o_adj   (w_det_adj),
        .o_det   (w_det)
    );

    // adjugate / determinant, truncated toward zero and saturated
    m3i_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_det_v),
        .i_adj   (w_det_adj),
        .i_det   (w_det),
        .o_valid (w_div_v),
        .o_res   (w_div_res)
    );

    // output register with skid slot
    m3i_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_v),
        .i_data  (w_div_res),
        .o_en    (w_en),
        .o_valid (w_out_v),
        .o_data  (w_out),
        .i_ready (o_res.ready)
    );

    assign o_res.valid       = w_out_v;
    assign o_res.inv00       = t_word'(w_out.inv[0]);
    assign o_res.inv01       = t_word'(w_out.inv[1]);
    assign o_res.inv02       = t_word'(w_out.inv[2]);
    assign o_res.inv10       = t_word'(w_out.inv[3]);
    assign o_res.inv11       = t_word'(w_out.inv[4]);
    assign o_res.inv12       = t_word'(w_out.inv[5]);
    assign o_res.inv20       = t_word'(w_out.inv[6]);
    assign o_res.inv21       = t_word'(w_out.inv[7]);
    assign o_res.inv22       = t_word'(w_out.inv[8]);
    assign o_res.determinant = t_word'(w_out.det);
    assign o_res.singular    = w_out.singular;

endmodule

### dv/matrix3x3_inverse_det_checker.sv
`timescale 1ns / 1ps
// scoreboard for the 3x3 inverse / determinant core: predicts each result beat
// from the accepted matrix beat and compares it; depends on m3i_pkg, m3i_if

module matrix3x3_inverse_det_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    m3i_in_if         i_mat,
    m3i_out_if        i_res,
    output int        o_fail_count,
    output int        o_pending
);
    import m3i_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef logic signed [127:0] t_wide;

    m3i_pkg::t_res inverse_q[$];

    // sign + magnitude to a saturated word
    function automatic t_word clamp_word(input logic neg, input logic [127:0] mag);
        if (neg) begin
            if (mag > 128'h8000_0000) return WORD_MIN;
            return t_word'(-mag[WORD-1:0]);
        end
        if (mag > 128'h7FFF_FFFF) return WORD_MAX;
        return t_word'(mag[WORD-1:0]);
    endfunction

    // exact cofactors and determinant in 128 bits, then truncating division
    function automatic m3i_pkg::t_res predict_inverse(input t_word e [9]);
        t_wide         w [9];
        t_wide         adj [9];
        t_wide         det;
        logic [127:0]  dmag;
        logic [127:0]  amag;
        logic          dneg;
        logic          aneg;
        m3i_pkg::t_res r;
        for (int k = 0; k < 9; k++) w[k] = t_wide'(e[k]);
        adj[0] =  (w[4] * w[8] - w[7] * w[5]);
        adj[1] = -(w[1] * w[8] - w[7] * w[2]);
        adj[2] =  (w[1] * w[5] - w[4] * w[2]);
        adj[3] = -(w[3] * w[8] - w[6] * w[5]);
        adj[4] =  (w[0] * w[8] - w[6] * w[2]);
        adj[5] = -(w[0] * w[5] - w[3] * w[2]);
        adj[6] =  (w[3] * w[7] - w[6] * w[4]);
        adj[7] = -(w[0] * w[7] - w[6] * w[1]);
        adj[8] =  (w[0] * w[4] - w[3] * w[1]);
        det = w[0] * adj[0] + w[1] * adj[3] + w[2] * adj[6];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        dneg = det[127];
        dmag = dneg ? -det : det;
        for (int k = 0; k < 9; k++) begin
            aneg = adj[k][127];
            amag = aneg ? -adj[k] : adj[k];
            r.inv[k] = clamp_word(aneg != dneg, (amag << (2 * FB)) / dmag);
        end
        r.det = clamp_word(dneg, dmag >> (2 * FB));
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_word         mat [9];
        t_word         got [10];
        m3i_pkg::t_res want;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_mat.valid && i_mat.ready) begin
                mat = '{i_mat.m00, i_mat.m01, i_mat.m02, i_mat.m10, i_mat.m11,
                        i_mat.m12, i_mat.m20, i_mat.m21, i_mat.m22};
                inverse_q.push_back(predict_inverse(mat));
            end
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.inv00, i_res.inv01, i_res.inv02, i_res.inv10,
                        i_res.inv11, i_res.inv12, i_res.inv20, i_res.inv21,
                        i_res.inv22, i_res.determinant};
                if (inverse_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    errs = errs + 1;
                end else begin
                    want = inverse_q.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        if (got[k] !== t_word'(want.inv[k])) begin
                            $display("%0t: inv entry %0d expected %0d actual %0d", $time,
                                     k, t_word'(want.inv[k]), got[k]);
                            errs = errs + 1;
                        end
                    end
                    if (got[9] !== t_word'(want.det)) begin
                        $display("%0t: determinant expected %0d actual %0d", $time,
                                 t_word'(want.det), got[9]);
                        errs = errs + 1;
                    end
                    if (i_res.singular !== want.singular) begin
                        $display("%0t: singular expected %0b actual %0b", $time,
                                 want.singular, i_res.singular);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= inverse_q.size();
        end
    end

endmodule

### dv/matrix3x3_inverse_det_core_tb.sv
`timescale 1ns / 1ps
// top of the 3x3 inverse / determinant testbench: clock, reset, matrix beats
// and result backpressure; depends on m3i_pkg, m3i_if and the checker

module matrix3x3_inverse_det_core_tb;
    import m3i_pkg::*;

    localparam int ONE       = 1 << FRAC_BITS_DEF;
    localparam int LATENCY   = 41;
    localparam int N_RANDOM  = 500;       // per idling phase
    localparam int MAX_CYC   = 400000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    int   send_idle_pct;
    int   recv_stall_pct;

    m3i_in_if  mat_ch ();
    m3i_out_if res_ch ();

    matrix3x3_inverse_det_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat_ch),
        .o_res   (res_ch)
    );

    matrix3x3_inverse_det_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mat        (mat_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver backpressure, redrawn every cycle
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("FAIL matrix3x3_inverse_det_core");
            $finish;
        end
    end

    // one matrix beat; valid stays high into the next beat when there is no gap
    task automatic send_matrix(input t_word e [9]);
        while ($urandom_range(99) < send_idle_pct) begin
            mat_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        mat_ch.valid <= 1'b1;
        {mat_ch.m00, mat_ch.m01, mat_ch.m02} <= {e[0], e[1], e[2]};
        {mat_ch.m10, mat_ch.m11, mat_ch.m12} <= {e[3], e[4], e[5]};
        {mat_ch.m20, mat_ch.m21, mat_ch.m22} <= {e[6], e[7], e[8]};
        @(posedge i_clk);
        while (!mat_ch.ready) @(posedge i_clk);
    endtask

    // entry of typical size: a few units in Q16.16 with a random fraction
    function automatic t_word typical_entry();
        return t_word'($signed($urandom_range(8 * ONE)) - 4 * ONE);
    endfunction

    task automatic send_random(input int n);
        t_word e [9];
        int    kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(9);
            for (int k = 0; k < 9; k++) begin
                if (kind < 5)       e[k] = typical_entry();
                else if (kind < 7)  e[k] = t_word'($urandom());
                else                e[k] = t_word'($signed($urandom_range(64)) - 32);
            end
            // rank-deficient: repeat or negate a row so the determinant is zero
            if (kind == 9) begin
                e[6] = e[0];
                e[7] = e[1];
                e[8] = e[2];
            end else if (kind == 8) begin
                e[3] = -e[0];
                e[4] = -e[1];
                e[5] = -e[2];
            end
            send_matrix(e);
        end
    endtask

    task automatic send_directed();
        t_word z = '0;
        t_word u = t_word'(ONE);
        // identity, zero, extremes, tiny and huge determinants
        send_matrix('{u, z, z, z, u, z, z, z, u});
        send_matrix('{z, z, z, z, z, z, z, z, z});
        send_matrix('{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                      WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX});
        send_matrix('{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                      WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN});
        send_matrix('{WORD_MAX, z, z, z, WORD_MAX, z, z, z, WORD_MAX});
        send_matrix('{WORD_MIN, z, z, z, WORD_MIN, z, z, z, WORD_MIN});
        send_matrix('{WORD_MIN, z, z, z, WORD_MAX, z, z, z, WORD_MIN});
        send_matrix('{t_word'(1), z, z, z, t_word'(1), z, z, z, t_word'(1)});
        send_matrix('{t_word'(-1), z, z, z, t_word'(1), z, z, z, t_word'(1)});
        send_matrix('{t_word'(2 * ONE), z, z, z, t_word'(4 * ONE), z, z, z,
                      t_word'(-ONE / 2)});
        send_matrix('{z, u, z, u, z, z, z, z, u});
        send_matrix('{z, z, u, z, u, z, u, z, z});
        send_matrix('{u, t_word'(2 * ONE), t_word'(3 * ONE), t_word'(4 * ONE),
                      t_word'(5 * ONE), t_word'(6 * ONE), t_word'(7 * ONE),
                      t_word'(8 * ONE), t_word'(10 * ONE)});
        send_matrix('{u, t_word'(2 * ONE), t_word'(3 * ONE), t_word'(4 * ONE),
                      t_word'(5 * ONE), t_word'(6 * ONE), t_word'(7 * ONE),
                      t_word'(8 * ONE), t_word'(9 * ONE)});
        send_matrix('{WORD_MAX, WORD_MIN, z, WORD_MIN, WORD_MAX, z, z, z, u});
        send_matrix('{t_word'(32'hAAAA_AAAA), t_word'(32'h5555_5555), z,
                      z, t_word'(32'h5555_5555), t_word'(32'hAAAA_AAAA),
                      t_word'(32'hAAAA_AAAA), z, t_word'(32'h5555_5555)});
        send_matrix('{t_word'(3), t_word'(1), z, z, t_word'(2), z, z, z,
                      t_word'(ONE)});
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    initial begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n      <= 1'b0;
        mat_ch.valid <= 1'b0;
        {mat_ch.m00, mat_ch.m01, mat_ch.m02} <= '0;
        {mat_ch.m10, mat_ch.m11, mat_ch.m12} <= '0;
        {mat_ch.m20, mat_ch.m21, mat_ch.m22} <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender sparse gaps, receiver stalls half the time
        send_idle_pct  = 6;
        recv_stall_pct = 50;
        send_directed();
        send_random(N_RANDOM);
        // roles swapped
        send_idle_pct  = 50;
        recv_stall_pct = 6;
        send_random(N_RANDOM);
        // full rate both ways
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_directed();
        send_random(N_RANDOM);
        mat_ch.valid <= 1'b0;
        drain();

        if (fail_count == 0) begin
            $display("PASS matrix3x3_inverse_det_core");
        end else begin
            $display("FAIL matrix3x3_inverse_det_core");
        end
        $finish;
    end

endmodule
